>>> sv/tlbp_pkg.sv
// Package with the shared types and constants of the two-level branch predictor.
`timescale 1ns / 1ps
package tlbp_pkg;

   localparam int MAX_ENTRIES = 32;
   localparam int MAX_HISTORY = 8;
   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int ROW_LEN = 1 << MAX_HISTORY;
   localparam int CTR_DEPTH = MAX_ENTRIES * ROW_LEN;
   localparam int CTR_AW = $clog2(CTR_DEPTH);
   localparam int TAG_W = 30;
   localparam int NUM_REGS = 7;

   localparam logic [2:0] REG_INDEX_BITS = 3'd0;
   localparam logic [2:0] REG_HISTORY_LEN = 3'd1;
   localparam logic [2:0] REG_TAG_WIDTH = 3'd2;
   localparam logic [2:0] REG_INIT_CTR = 3'd3;
   localparam logic [2:0] REG_GLOBAL_HIST = 3'd4;
   localparam logic [2:0] REG_SHARED_TABLE = 3'd5;
   localparam logic [2:0] REG_SHARE_MODE = 3'd6;

   localparam logic [1:0] SHARE_NONE = 2'd0;
   localparam logic [1:0] SHARE_PC2 = 2'd1;
   localparam logic [1:0] SHARE_PC16 = 2'd2;

   localparam logic KIND_PREDICT = 1'b0;
   localparam logic KIND_UPDATE = 1'b1;

   // Effective configuration after saturation of out-of-range values.
   typedef struct packed {
      logic [2:0] index_bits;
      logic [3:0] history_len;
      logic [4:0] tag_width;
      logic [1:0] init_ctr;
      logic       global_hist;
      logic       shared_table;
      logic [1:0] share_mode;
   } cfg_type;

   // A request after classification by the front part.
   typedef struct packed {
      logic              kind;
      logic              taken;
      logic [31:0]       pc;
      logic [31:0]       actual_target;
      logic [31:0]       earlier_prediction;
      logic [IDX_W-1:0]  entry;
      logic [TAG_W-1:0]  tag;
   } req_info_type;

   typedef struct packed {
      logic        predict_taken;
      logic [31:0] next_address;
      logic [31:0] branch_count;
      logic [31:0] flush_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_ROWCLR,
      ST_EXEC
   } state_type;

endpackage

>>> sv/tlbp_front.sv
// Request queue that also splits each branch address into entry index and tag.
`timescale 1ns / 1ps
module tlbp_front
   import tlbp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         push,
   output logic         full,
   input  logic         kind,
   input  logic [31:0]  pc,
   input  logic         taken,
   input  logic [31:0]  actual_target,
   input  logic [31:0]  earlier_prediction,
   output logic         head_valid,
   output req_info_type head_info,
   input  logic         head_pop
);

   typedef struct packed {
      logic        kind;
      logic        taken;
      logic [31:0] pc;
      logic [31:0] actual_target;
      logic [31:0] earlier_prediction;
   } raw_type;

   raw_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;
   raw_type    head;
   logic [IDX_W-1:0] imask;
   logic [31:0]      tmask;
   logic [31:0]      shifted;

   assign full = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign do_push = push && !full;
   assign do_pop = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= '{kind, taken, pc, actual_target, earlier_prediction};
      end
   end

   // The index takes pc bits from bit two upward, the tag the bits right above the index.
   always_comb begin
      head = slot_ff[rd_ptr_ff];
      imask = IDX_W'((({1'b0, {IDX_W{1'b0}}}) | (IDX_W + 1)'(1)) << cfg.index_bits) - IDX_W'(1);
      tmask = 32'((33'd1 << cfg.tag_width) - 33'd1);
      shifted = head.pc >> (6'(cfg.index_bits) + 6'd2);
      head_info.kind = head.kind;
      head_info.taken = head.taken;
      head_info.pc = head.pc;
      head_info.actual_target = head.actual_target;
      head_info.earlier_prediction = head.earlier_prediction;
      head_info.entry = head.pc[IDX_W+1:2] & imask;
      head_info.tag = TAG_W'(shifted & tmask);
   end

endmodule

>>> sv/tlbp_back.sv
// Prediction engine: target buffer, histories, counter memory and statistics.
`timescale 1ns / 1ps
module tlbp_back
   import tlbp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         clear,
   input  logic         head_valid,
   input  req_info_type head_info,
   output logic         head_pop,
   output logic         rsp_valid,
   output rsp_type      rsp,
   input  logic         rsp_pop
);

   state_type state_ff, state_in;

   logic                 valid_ff [MAX_ENTRIES];
   logic [TAG_W-1:0]     tag_ff [MAX_ENTRIES];
   logic [31:0]          target_ff [MAX_ENTRIES];
   logic [MAX_HISTORY-1:0] lhist_ff [MAX_ENTRIES];
   logic [MAX_HISTORY-1:0] shist_ff;
   logic [1:0]           ctr_mem [CTR_DEPTH];
   logic [1:0]           ctr_rd_ff;

   req_info_type         item_ff;
   logic                 known_ff;
   logic                 use_init_ff;
   logic [MAX_HISTORY-1:0] old_ff;
   logic [CTR_AW-1:0]    addr_ff;
   logic [CTR_AW-1:0]    sweep_ff, sweep_in;
   logic [31:0]          branches_ff, flushes_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic [MAX_HISTORY-1:0] hmask, hsrc, old_val, pc_bits, fi, new_hist;
   logic                 known, use_hist, row_clear, flush;
   logic [IDX_W-1:0]     row;
   logic [1:0]           ctr_cur, ctr_new;
   logic [31:0]          pc4;
   logic                 ctr_we;
   logic [CTR_AW-1:0]    ctr_waddr;
   logic [1:0]           ctr_wdata;

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   // Lookup for the held request.
   always_comb begin
      hmask = MAX_HISTORY'(((MAX_HISTORY + 1)'(1) << cfg.history_len) - (MAX_HISTORY + 1)'(1));
      known = valid_ff[item_ff.entry] && (tag_ff[item_ff.entry] == item_ff.tag);
      hsrc = cfg.global_hist ? shist_ff : lhist_ff[item_ff.entry];
      use_hist = known || cfg.global_hist;
      old_val = use_hist ? (hsrc & hmask) : '0;
      case (cfg.share_mode)
         SHARE_PC2: pc_bits = item_ff.pc[MAX_HISTORY+1:2];
         SHARE_PC16: pc_bits = item_ff.pc[MAX_HISTORY+15:16];
         default: pc_bits = '0;
      endcase
      fi = (old_val ^ pc_bits) & hmask;
      row = cfg.shared_table ? '0 : item_ff.entry;
      row_clear = (item_ff.kind == KIND_UPDATE) && !known && !cfg.shared_table;
   end

   // Training values for the execute step.
   always_comb begin
      ctr_cur = use_init_ff ? cfg.init_ctr : ctr_rd_ff;
      if (item_ff.taken) begin
         ctr_new = (ctr_cur == 2'd3) ? ctr_cur : ctr_cur + 2'd1;
      end else begin
         ctr_new = (ctr_cur == 2'd0) ? ctr_cur : ctr_cur - 2'd1;
      end
      pc4 = item_ff.pc + 32'd4;
      new_hist = (known_ff || cfg.global_hist) ?
                 (((old_ff << 1) & hmask) | MAX_HISTORY'(item_ff.taken)) :
                 MAX_HISTORY'(item_ff.taken);
      flush = item_ff.taken ? (item_ff.actual_target != item_ff.earlier_prediction) :
                              (item_ff.earlier_prediction != pc4);
   end

   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      head_pop = 1'b0;
      ctr_we = 1'b0;
      ctr_waddr = addr_ff;
      ctr_wdata = ctr_new;
      case (state_ff)
         ST_CLEAR: begin
            ctr_we = 1'b1;
            ctr_waddr = sweep_ff;
            ctr_wdata = cfg.init_ctr;
            sweep_in = sweep_ff + CTR_AW'(1);
            if (sweep_ff == CTR_AW'(CTR_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head_valid && (!rsp_valid_ff || rsp_pop)) begin
               head_pop = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            sweep_in = {row, {MAX_HISTORY{1'b0}}};
            state_in = row_clear ? ST_ROWCLR : ST_EXEC;
         end
         ST_ROWCLR: begin
            ctr_we = 1'b1;
            ctr_waddr = sweep_ff;
            ctr_wdata = cfg.init_ctr;
            sweep_in = sweep_ff + CTR_AW'(1);
            if (sweep_ff[MAX_HISTORY-1:0] == {MAX_HISTORY{1'b1}}) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctr_we = (item_ff.kind == KIND_UPDATE);
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (clear) begin
         state_in = ST_CLEAR;
         sweep_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         sweep_ff <= '0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
      end
   end

   // Counter memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (ctr_we) begin
         ctr_mem[ctr_waddr] <= ctr_wdata;
      end
      ctr_rd_ff <= ctr_mem[{row, fi}];
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         item_ff <= head_info;
      end
      if (state_ff == ST_LOOK) begin
         known_ff <= known;
         old_ff <= old_val;
         addr_ff <= {row, fi};
         use_init_ff <= row_clear;
      end
      if (state_ff == ST_EXEC && item_ff.kind == KIND_UPDATE) begin
         tag_ff[item_ff.entry] <= item_ff.tag;
         target_ff[item_ff.entry] <= item_ff.actual_target;
      end
      if (state_ff == ST_EXEC) begin
         if (item_ff.kind == KIND_UPDATE) begin
            rsp_ff.predict_taken <= 1'b0;
            rsp_ff.next_address <= '0;
            rsp_ff.branch_count <= (branches_ff == '1) ? branches_ff : branches_ff + 32'd1;
            rsp_ff.flush_count <= (flush && flushes_ff != '1) ? flushes_ff + 32'd1 : flushes_ff;
         end else begin
            rsp_ff.predict_taken <= known_ff && ctr_cur[1];
            rsp_ff.next_address <= (known_ff && ctr_cur[1]) ? target_ff[item_ff.entry] : pc4;
            rsp_ff.branch_count <= branches_ff;
            rsp_ff.flush_count <= flushes_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            lhist_ff[i] <= '0;
         end
         shist_ff <= '0;
         branches_ff <= '0;
         flushes_ff <= '0;
      end else if (state_ff == ST_EXEC && item_ff.kind == KIND_UPDATE) begin
         valid_ff[item_ff.entry] <= 1'b1;
         if (cfg.global_hist) begin
            shist_ff <= new_hist;
         end else begin
            lhist_ff[item_ff.entry] <= new_hist;
         end
         if (branches_ff != '1) begin
            branches_ff <= branches_ff + 32'd1;
         end
         if (flush && flushes_ff != '1) begin
            flushes_ff <= flushes_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_EXEC) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   a_exec_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> !rsp_valid_ff)
      else $error("result slot occupied at execute");

   a_no_pop_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR || state_ff == ST_ROWCLR) |-> !head_pop)
      else $error("request taken during a counter sweep");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !clear |=> branches_ff >= $past(branches_ff))
      else $error("branch count decreased without a clear");

endmodule

>>> sv/two_level_branch_predictor.sv
// Top level of the two-level branch predictor with its configuration registers.
`timescale 1ns / 1ps
// Usage:
// Requests enter through a queue port: drive req_* and raise req_push; the
// request is taken at a clock edge where req_full is low. req_kind selects a
// prediction (0) or a resolved-branch update (1). Results leave through a
// second queue port: while rsp_empty is low the oldest result sits on rsp_*
// and is taken at an edge where rsp_pop is high.
// A request waits at the head of the request queue while the engine selects it,
// then passes a lookup step with the counter read and an execute step, after
// which its result is registered on rsp_*. The engine takes the next request
// only once it is through with the last one and its result slot is free.
// An update that misses while each entry owns its counter table first sweeps
// that table row back to the initial counter value before it executes.
// Reset and every write to a configuration register start a sweep of the whole
// 8192-entry counter memory, during which no request is serviced; requests
// still queue up to the queue depth of two. csr_* writes take effect at once
// and must be issued only while no request is outstanding.
// When the receiver stalls, one result waits on the outputs, the engine holds
// off, and the request queue fills and then raises req_full.
module two_level_branch_predictor
   import tlbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_kind,
   input  logic [31:0] req_pc,
   input  logic        req_taken,
   input  logic [31:0] req_actual_target,
   input  logic [31:0] req_earlier_prediction,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_predict_taken,
   output logic [31:0] rsp_next_address,
   output logic [31:0] rsp_branch_count,
   output logic [31:0] rsp_flush_count,
   output logic [14:0] rsp_storage_bits,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [4:0]  csr_wdata
);

   logic [2:0] index_bits_ff;
   logic [3:0] history_len_ff;
   logic [4:0] tag_width_ff;
   logic [1:0] init_ctr_ff;
   logic       global_hist_ff;
   logic       shared_table_ff;
   logic [1:0] share_mode_ff;
   logic [14:0] storage_ff;

   cfg_type      cfg;
   logic         clear;
   logic         head_valid, head_pop, rsp_valid;
   req_info_type head_info;
   rsp_type      rsp;
   logic [4:0]   tag_lim;
   logic [14:0]  btb_bits, hist_bits, ctr_bits;

   // Any write to a defined register returns all predictor state to reset.
   assign clear = csr_we && (csr_index < 3'(NUM_REGS));

   always_ff @(posedge clock) begin
      if (reset) begin
         index_bits_ff <= 3'd0;
         history_len_ff <= 4'd1;
         tag_width_ff <= 5'd0;
         init_ctr_ff <= 2'd1;
         global_hist_ff <= 1'b0;
         shared_table_ff <= 1'b0;
         share_mode_ff <= SHARE_NONE;
      end else if (csr_we) begin
         case (csr_index)
            REG_INDEX_BITS: index_bits_ff <= csr_wdata[2:0];
            REG_HISTORY_LEN: history_len_ff <= csr_wdata[3:0];
            REG_TAG_WIDTH: tag_width_ff <= csr_wdata;
            REG_INIT_CTR: init_ctr_ff <= csr_wdata[1:0];
            REG_GLOBAL_HIST: global_hist_ff <= csr_wdata[0];
            REG_SHARED_TABLE: shared_table_ff <= csr_wdata[0];
            REG_SHARE_MODE: share_mode_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // Out-of-range settings saturate; share mode three behaves as history only.
   always_comb begin
      cfg.index_bits = (index_bits_ff > 3'(IDX_W)) ? 3'(IDX_W) : index_bits_ff;
      if (history_len_ff == 4'd0) begin
         cfg.history_len = 4'd1;
      end else if (history_len_ff > 4'(MAX_HISTORY)) begin
         cfg.history_len = 4'(MAX_HISTORY);
      end else begin
         cfg.history_len = history_len_ff;
      end
      tag_lim = 5'd30 - 5'(cfg.index_bits);
      cfg.tag_width = (tag_width_ff < tag_lim) ? tag_width_ff : tag_lim;
      cfg.init_ctr = init_ctr_ff;
      cfg.global_hist = global_hist_ff;
      cfg.shared_table = shared_table_ff;
      cfg.share_mode = (share_mode_ff == SHARE_PC2 || share_mode_ff == SHARE_PC16) ?
                       share_mode_ff : SHARE_NONE;
   end

   // Storage size: every entry count is a power of two, so products are shifts.
   always_comb begin
      btb_bits = (15'(cfg.tag_width) + 15'd31) << cfg.index_bits;
      hist_bits = cfg.global_hist ? 15'(cfg.history_len) :
                  (15'(cfg.history_len) << cfg.index_bits);
      ctr_bits = cfg.shared_table ? (15'd1 << (cfg.history_len + 4'd1)) :
                 (15'd1 << (5'(cfg.history_len) + 5'd1 + 5'(cfg.index_bits)));
   end

   always_ff @(posedge clock) begin
      storage_ff <= btb_bits + hist_bits + ctr_bits;
   end

   tlbp_front u_front (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .push               (req_push),
      .full               (req_full),
      .kind               (req_kind),
      .pc                 (req_pc),
      .taken              (req_taken),
      .actual_target      (req_actual_target),
      .earlier_prediction (req_earlier_prediction),
      .head_valid         (head_valid),
      .head_info          (head_info),
      .head_pop           (head_pop)
   );

   tlbp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .clear      (clear),
      .head_valid (head_valid),
      .head_info  (head_info),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp),
      .rsp_pop    (rsp_pop)
   );

   assign rsp_empty = !rsp_valid;
   assign rsp_predict_taken = rsp.predict_taken;
   assign rsp_next_address = rsp.next_address;
   assign rsp_branch_count = rsp.branch_count;
   assign rsp_flush_count = rsp.flush_count;
   assign rsp_storage_bits = storage_ff;

endmodule

>>> test/tb_two_level_branch_predictor.sv
// Self-checking testbench for the two-level branch predictor.
`timescale 1ns / 1ps

typedef struct {
   bit        predict_taken;
   bit [31:0] next_address;
   bit [31:0] branch_count;
   bit [31:0] flush_count;
   bit [14:0] storage_bits;
} bp_result_type;

// Tracks the predictor state and the results that accepted requests should produce.
class bp_scoreboard;
   // Register values exactly as written.
   bit [2:0]  r_index_bits;
   bit [3:0]  r_history_len;
   bit [4:0]  r_tag_width;
   bit [1:0]  r_init_ctr;
   bit        r_global_hist;
   bit        r_shared_table;
   bit [1:0]  r_share_mode;

   bit        ent_valid [32];
   bit [29:0] ent_tag [32];
   bit [31:0] ent_target [32];
   bit [7:0]  hist_local [32];
   bit [7:0]  hist_shared;
   bit [1:0]  dir_ctr [8192];
   bit [31:0] branches;
   bit [31:0] flushes;

   bp_result_type results_due[$];
   int errors;

   function new();
      r_index_bits = 0;
      r_history_len = 1;
      r_tag_width = 0;
      r_init_ctr = 1;
      r_global_hist = 0;
      r_shared_table = 0;
      r_share_mode = 0;
      errors = 0;
      clear_tables();
   endfunction

   function void clear_tables();
      for (int i = 0; i < 32; i++) begin
         ent_valid[i] = 0;
         ent_tag[i] = 0;
         ent_target[i] = 0;
         hist_local[i] = 0;
      end
      for (int i = 0; i < 8192; i++) dir_ctr[i] = r_init_ctr;
      hist_shared = 0;
      branches = 0;
      flushes = 0;
   endfunction

   function void write_reg(bit [2:0] idx, bit [4:0] val);
      case (idx)
         tlbp_pkg::REG_INDEX_BITS: r_index_bits = val[2:0];
         tlbp_pkg::REG_HISTORY_LEN: r_history_len = val[3:0];
         tlbp_pkg::REG_TAG_WIDTH: r_tag_width = val;
         tlbp_pkg::REG_INIT_CTR: r_init_ctr = val[1:0];
         tlbp_pkg::REG_GLOBAL_HIST: r_global_hist = val[0];
         tlbp_pkg::REG_SHARED_TABLE: r_shared_table = val[0];
         tlbp_pkg::REG_SHARE_MODE: r_share_mode = val[1:0];
         default: return;
      endcase
      clear_tables();
   endfunction

   // Works out one request against the state; the state is trained only when apply is set.
   function bp_result_type evaluate(bit kind, bit [31:0] pc, bit taken, bit [31:0] actual,
                                    bit [31:0] earlier, bit apply);
      int unsigned ib, hl, tw, hmask, bi, old, fi, row, entries, storage;
      bit [29:0] tag;
      bit [31:0] pc4;
      bit hit, use_hist;
      bp_result_type r;
      ib = (r_index_bits > 5) ? 5 : r_index_bits;
      hl = (r_history_len == 0) ? 1 : ((r_history_len > 8) ? 8 : r_history_len);
      tw = (r_tag_width > 30 - ib) ? 30 - ib : r_tag_width;
      hmask = (1 << hl) - 1;
      bi = (pc >> 2) & ((1 << ib) - 1);
      tag = (pc >> (ib + 2)) & ((1 << tw) - 1);
      pc4 = pc + 32'd4;
      hit = ent_valid[bi] && ent_tag[bi] == tag;
      use_hist = hit || r_global_hist;
      old = use_hist ? ((r_global_hist ? hist_shared : hist_local[bi]) & hmask) : 0;
      if (r_share_mode == tlbp_pkg::SHARE_PC2) fi = (old ^ (pc >> 2)) & hmask;
      else if (r_share_mode == tlbp_pkg::SHARE_PC16) fi = (old ^ (pc >> 16)) & hmask;
      else fi = old & hmask;
      row = r_shared_table ? 0 : bi;
      r.predict_taken = 0;
      r.next_address = 0;
      if (kind == tlbp_pkg::KIND_PREDICT) begin
         r.predict_taken = hit && dir_ctr[row * 256 + fi] >= 2;
         r.next_address = r.predict_taken ? ent_target[bi] : pc4;
      end else if (apply) begin
         // A new entry with its own counter row starts that row afresh.
         if (!hit && !r_shared_table)
            for (int i = 0; i < 256; i++) dir_ctr[row * 256 + i] = r_init_ctr;
         if (r_global_hist) hist_shared = ((old << 1) & hmask) | taken;
         else hist_local[bi] = use_hist ? (((old << 1) & hmask) | taken) : taken;
         ent_tag[bi] = tag;
         ent_target[bi] = actual;
         ent_valid[bi] = 1;
         if (taken && dir_ctr[row * 256 + fi] != 3) dir_ctr[row * 256 + fi]++;
         if (!taken && dir_ctr[row * 256 + fi] != 0) dir_ctr[row * 256 + fi]--;
         if (branches != 32'hFFFF_FFFF) branches++;
         if (((taken && actual != earlier) || (!taken && earlier != pc4))
             && flushes != 32'hFFFF_FFFF) flushes++;
      end
      entries = 1 << ib;
      storage = entries * (tw + 31);
      storage += r_global_hist ? hl : entries * hl;
      storage += r_shared_table ? (1 << (hl + 1)) : entries * (1 << (hl + 1));
      r.branch_count = branches;
      r.flush_count = flushes;
      r.storage_bits = storage[14:0];
      return r;
   endfunction

   function void note_request(bit kind, bit [31:0] pc, bit taken, bit [31:0] actual,
                              bit [31:0] earlier);
      results_due.push_back(evaluate(kind, pc, taken, actual, earlier, 1));
   endfunction

   function void check_result(bit pt, bit [31:0] na, bit [31:0] bc, bit [31:0] fc,
                              bit [14:0] sb);
      bp_result_type e;
      if (results_due.size() == 0) begin
         $error("result with no request outstanding");
         errors++;
         return;
      end
      e = results_due.pop_front();
      if (pt != e.predict_taken) begin
         $error("predict_taken: expected %0d, got %0d", e.predict_taken, pt);
         errors++;
      end
      if (na != e.next_address) begin
         $error("next_address: expected %h, got %h", e.next_address, na);
         errors++;
      end
      if (bc != e.branch_count) begin
         $error("branch_count: expected %0d, got %0d", e.branch_count, bc);
         errors++;
      end
      if (fc != e.flush_count) begin
         $error("flush_count: expected %0d, got %0d", e.flush_count, fc);
         errors++;
      end
      if (sb != e.storage_bits) begin
         $error("storage_bits: expected %0d, got %0d", e.storage_bits, sb);
         errors++;
      end
   endfunction
endclass

module tb_two_level_branch_predictor;
   import tlbp_pkg::*;

   // Covers the slowest legal run: every update missing a private row, stalls and sweeps.
   localparam int CYCLE_LIMIT = 3_000_000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_push = 0;
   logic        req_full;
   logic        req_kind = 0;
   logic [31:0] req_pc = 0;
   logic        req_taken = 0;
   logic [31:0] req_actual_target = 0;
   logic [31:0] req_earlier_prediction = 0;
   logic        rsp_empty;
   logic        rsp_pop = 0;
   logic        rsp_predict_taken;
   logic [31:0] rsp_next_address;
   logic [31:0] rsp_branch_count;
   logic [31:0] rsp_flush_count;
   logic [14:0] rsp_storage_bits;
   logic        csr_we = 0;
   logic [2:0]  csr_index = 0;
   logic [4:0]  csr_wdata = 0;

   two_level_branch_predictor u_top (.*);

   bp_scoreboard predictor_model = new();

   // Percent chance of an idle cycle on each side, and a forced stall on the result side.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int recv_hold_left = 0;
   int request_count = 0;
   int cycle_count = 0;
   bit [31:0] pc_pool [8];

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("two_level_branch_predictor test failed");
         $finish;
      end
   end

   // Result side. Outputs are sampled on the falling edge, when they are stable, and a
   // result counts as taken at the next rising edge if pop was high there.
   logic        s_empty;
   logic        s_pt;
   logic [31:0] s_na, s_bc, s_fc;
   logic [14:0] s_sb;

   always @(negedge clock) begin
      s_empty <= rsp_empty;
      s_pt <= rsp_predict_taken;
      s_na <= rsp_next_address;
      s_bc <= rsp_branch_count;
      s_fc <= rsp_flush_count;
      s_sb <= rsp_storage_bits;
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !s_empty)
         predictor_model.check_result(s_pt, s_na, s_bc, s_fc, s_sb);
      if (recv_hold_left > 0) begin
         recv_hold_left <= recv_hold_left - 1;
         rsp_pop <= 0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offers one request and returns at the edge where it is taken. push stays high on
   // return, so a following request carries on without a gap.
   task automatic send_request(bit kind, bit [31:0] pc, bit taken, bit [31:0] actual,
                               bit [31:0] earlier);
      bit was_full;
      req_push <= 1;
      req_kind <= kind;
      req_pc <= pc;
      req_taken <= taken;
      req_actual_target <= actual;
      req_earlier_prediction <= earlier;
      do begin
         @(negedge clock);
         was_full = req_full;
         @(posedge clock);
      end while (was_full);
      predictor_model.note_request(kind, pc, taken, actual, earlier);
      request_count++;
   endtask

   task automatic idle_sender(int cycles);
      req_push <= 0;
      repeat (cycles) @(posedge clock);
   endtask

   // Random gaps on the request side, at the rate of the current idling phase.
   task automatic maybe_gap();
      if ($urandom_range(99) < send_idle_pct) idle_sender($urandom_range(1, 4));
   endtask

   task automatic drain();
      req_push <= 0;
      while (predictor_model.results_due.size() != 0) @(posedge clock);
      // One last look for a stray result before anything changes.
      repeat (8) @(posedge clock);
   endtask

   task automatic program_regs(bit [4:0] ib, bit [4:0] hl, bit [4:0] tw, bit [4:0] ic,
                               bit [4:0] gh, bit [4:0] gt, bit [4:0] sm);
      bit [4:0] vals [7];
      vals = '{ib, hl, tw, ic, gh, gt, sm};
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_we <= 1;
         csr_index <= i[2:0];
         csr_wdata <= vals[i];
         @(posedge clock);
         predictor_model.write_reg(i[2:0], vals[i]);
      end
      csr_we <= 0;
   endtask

   // Sets how often each side idles from how far the random part has come.
   task automatic pick_idling();
      if (request_count < 330) begin
         send_idle_pct = 19;
         recv_idle_pct = 54;
      end else if (request_count < 660) begin
         send_idle_pct = 54;
         recv_idle_pct = 19;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   // One random request. Most requests reuse a small set of branch addresses so that
   // entries hit and counters train; the rest use an arbitrary address.
   task automatic random_request();
      bit [31:0] pc, actual, earlier;
      bit kind, taken;
      bp_result_type guess;
      pick_idling();
      pc = ($urandom_range(9) == 0) ? $urandom() : pc_pool[$urandom_range(7)];
      kind = $urandom_range(1);
      taken = $urandom_range(1);
      actual = ($urandom_range(3) == 0) ? $urandom() : pc ^ 32'h0000_0100;
      guess = predictor_model.evaluate(KIND_PREDICT, pc, 0, 0, 0, 0);
      case ($urandom_range(4))
         0: earlier = $urandom();
         1: earlier = pc + 32'd4;
         2: earlier = actual;
         default: earlier = guess.next_address;
      endcase
      send_request(kind, pc, taken, actual, earlier);
      maybe_gap();
   endtask

   task automatic random_phase(int count);
      for (int i = 0; i < 8; i++) pc_pool[i] = $urandom();
      repeat (count) random_request();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;

      // Reset settings: one entry, one history bit, no tag. Covers a miss, the
      // new-entry path, counter saturation both ways, both kinds of flush and the
      // wrap of pc+4 at the top of the address space.
      send_request(KIND_PREDICT, 32'h0, 0, 32'h0, 32'h0);
      send_request(KIND_UPDATE, 32'h0, 1, 32'hFFFF_FFFF, 32'h4);
      send_request(KIND_PREDICT, 32'h0, 0, 32'h0, 32'h0);
      send_request(KIND_UPDATE, 32'h0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(KIND_UPDATE, 32'h0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(KIND_UPDATE, 32'h0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(KIND_PREDICT, 32'h0, 0, 32'h0, 32'h0);
      send_request(KIND_PREDICT, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(KIND_UPDATE, 32'hFFFF_FFFF, 0, 32'h0, 32'h3);
      send_request(KIND_UPDATE, 32'hFFFF_FFFF, 0, 32'h0, 32'h0);
      send_request(KIND_UPDATE, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 32'h1234_5678);
      send_request(KIND_UPDATE, 32'hFFFF_FFFF, 0, 32'h0, 32'h3);
      send_request(KIND_PREDICT, 32'hFFFF_FFFF, 0, 32'h0, 32'h0);
      send_request(KIND_PREDICT, 32'hFFFF_FFFC, 0, 32'h0, 32'h0);
      drain();

      // Widest tables, shared history and counters, pc folded in from bit 2.
      program_regs(5, 8, 30, 3, 1, 1, 1);
      send_request(KIND_UPDATE, 32'hFFFF_FFFC, 0, 32'hAAAA_AAAA, 32'h0);
      send_request(KIND_PREDICT, 32'hFFFF_FFFC, 0, 32'h0, 32'h0);
      send_request(KIND_UPDATE, 32'h0000_0004, 1, 32'h5555_5555, 32'h5555_5555);
      send_request(KIND_PREDICT, 32'h0000_0004, 0, 32'h0, 32'h0);
      random_phase(160);
      drain();

      // Out-of-range values: index and tag saturate, history length of zero.
      program_regs(7, 0, 31, 0, 0, 0, 2);
      random_phase(160);
      drain();

      // Private counter rows under shared history, an over-long history and the
      // unused share mode. The result side stalls for a long stretch here while
      // requests keep coming, and later the sender waits for every result.
      program_regs(2, 15, 3, 2, 1, 0, 3);
      random_phase(60);
      recv_hold_left = 400;
      repeat (12) random_request();
      random_phase(40);
      drain();
      random_phase(60);
      drain();

      // A write to the index past the last register must change nothing.
      program_regs(3, 4, 10, 1, 0, 1, 1);
      csr_we <= 1;
      csr_index <= 3'd7;
      csr_wdata <= 5'h1F;
      @(posedge clock);
      predictor_model.write_reg(3'd7, 5'h1F);
      csr_we <= 0;
      random_phase(160);
      drain();

      program_regs(0, 8, 0, 3, 0, 0, 0);
      random_phase(280);
      drain();

      if (predictor_model.errors == 0)
         $display("two_level_branch_predictor test passed");
      else
         $display("two_level_branch_predictor test failed");
      $finish;
   end
endmodule
